// ----- rtl/order_fifo_with_search_top_macros.svh -----
// Assertion macros for the order FIFO RTL.
`ifndef ORDER_FIFO_WITH_SEARCH_TOP_MACROS_SVH
`define ORDER_FIFO_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define OFS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define OFS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ofs_pkg.sv -----
// Types and constants of the order FIFO with search.
package ofs_pkg;

   localparam int ID_W    = 16;
   localparam int ST_W    = 2;
   localparam int ROB_W   = 8;
   localparam int CNT_W   = 5;
   localparam int RTYPE_W = 3;

   // request codes
   localparam logic [RTYPE_W-1:0] REQ_ENQ      = 3'd0;
   localparam logic [RTYPE_W-1:0] REQ_DEQ      = 3'd1;
   localparam logic [RTYPE_W-1:0] REQ_PEEK     = 3'd2;
   localparam logic [RTYPE_W-1:0] REQ_PEND     = 3'd3;
   localparam logic [RTYPE_W-1:0] REQ_ASSIGN   = 3'd4;
   localparam logic [RTYPE_W-1:0] REQ_CONTAINS = 3'd5;
   localparam logic [RTYPE_W-1:0] REQ_ADD      = 3'd6;

   // entry status codes
   localparam logic [ST_W-1:0] ST_PENDING  = 2'd0;
   localparam logic [ST_W-1:0] ST_ASSIGNED = 2'd1;

   // compare modes of the shared match unit
   localparam logic [1:0] MATCH_ANY  = 2'd0;
   localparam logic [1:0] MATCH_PEND = 2'd1;
   localparam logic [1:0] MATCH_ID   = 2'd2;

   typedef struct packed {
      logic [RTYPE_W-1:0]      req_type;
      logic [ID_W-1:0]         order_id;
      logic [ID_W-1:0]         item_id;
      logic [ST_W-1:0]         order_status;
      logic signed [ROB_W-1:0] robot_id;
   } req_beat_type;

   typedef struct packed {
      logic                    ok;
      logic [ID_W-1:0]         out_order_id;
      logic [ID_W-1:0]         out_item_id;
      logic [ST_W-1:0]         out_status;
      logic signed [ROB_W-1:0] out_robot_id;
      logic [CNT_W-1:0]        queue_count;
   } rsp_beat_type;

   typedef struct packed {
      logic [ID_W-1:0]         oid;
      logic [ID_W-1:0]         item;
      logic [ST_W-1:0]         stat;
      logic signed [ROB_W-1:0] robot;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]      mode;
      logic [ID_W-1:0] key;
   } match_ctl_type;

endpackage

// ----- rtl/ofs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ofs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/ofs_match.sv -----
// Shared compare unit: tests one stored entry by mode: any, pending, or id key.
module ofs_match (
   input  ofs_pkg::match_ctl_type ctl,
   input  ofs_pkg::entry_type     entry,
   output logic                   hit
);
   import ofs_pkg::*;

   always_comb begin
      case (ctl.mode)
         MATCH_ANY:  hit = 1'b1;
         MATCH_PEND: hit = (entry.stat == ST_PENDING);
         MATCH_ID:   hit = (entry.oid == ctl.key);
         default:    hit = 1'b0;
      endcase
   end

endmodule

// ----- rtl/order_fifo_with_search_top.sv -----
// Top level of the order FIFO with associative search over queue and history.
//
// Bounded FIFO of order entries plus an append-only list of completed ids.
// Request channel (req_valid/req_stall/req_data) carries one request per beat;
// result channel (rsp_valid/rsp_stall/rsp_data) returns exactly one beat each.
// One request is worked at a time: req_stall is high from accept until the
// result has been loaded into the output register. A result that waits on
// rsp_stall does not hold up the next request; only a second finished result
// waits until the output register is free.
// Enqueue, add completed and unused codes go straight to the output state;
// dequeue and peek return the head entry; first pending and assign scan the
// queue from the head to the first match; contains scans the queue and,
// if no match is found there, the history.
// The queue and history RAMs are scanned one entry per cycle through one
// registered read port each, feeding a single compare unit; the length
// of that scan sets the worst-case latency.
// Reset (synchronous, active high) empties queue and history by clearing
// the counts and pointers; RAM contents are not cleared.
module order_fifo_with_search_top #(
   parameter int QUEUE_DEPTH   = 16,
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ofs_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ofs_pkg::rsp_beat_type rsp_data
);
   import ofs_pkg::*;

   `include "order_fifo_with_search_top_macros.svh"

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int HCW = $clog2(HISTORY_DEPTH + 1);

   localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
   localparam logic [HCW-1:0] HFULL = HCW'(HISTORY_DEPTH);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_QSCAN = 2'd1;
   localparam logic [1:0] S_HSCAN = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   function automatic logic [QAW-1:0] qnext(input logic [QAW-1:0] i);
      return (i == QLAST) ? '0 : i + 1'b1;
   endfunction

   function automatic rsp_beat_type rsp_of(input entry_type e);
      rsp_beat_type r;
      r              = '0;
      r.ok           = 1'b1;
      r.out_order_id = e.oid;
      r.out_item_id  = e.item;
      r.out_status   = e.stat;
      r.out_robot_id = e.robot;
      return r;
   endfunction

   logic [1:0]     state_ff, state_in;
   req_beat_type   req_ff, req_in;
   logic [QAW-1:0] head_ff, head_in;
   logic [QAW-1:0] tail_ff, tail_in;
   logic [QCW-1:0] count_ff, count_in;
   logic [HCW-1:0] hcount_ff, hcount_in;
   logic [QAW-1:0] qa_ff, qa_in;       // next queue address to read
   logic [QCW-1:0] qn_ff, qn_in;       // queue reads issued
   logic [QAW-1:0] rp_ff, rp_in;       // address of data now on the RAM output
   logic [HCW-1:0] hn_ff, hn_in;       // history reads issued
   logic           rv_ff, rv_in;       // RAM output holds a scanned entry
   rsp_beat_type   res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_beat_type   rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               qwe;
   logic [QAW-1:0]     qwaddr;
   logic [ENTRY_W-1:0] qwdata;
   logic [ENTRY_W-1:0] q_rdata;
   logic               hwe;
   logic [ID_W-1:0]    h_rdata;
   entry_type          q_entry;
   entry_type          upd_entry;
   entry_type          m_entry;
   match_ctl_type      m_ctl;
   logic               m_hit;
   logic               hit;
   logic               q_issue;
   logic               h_issue;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign q_entry   = entry_type'(q_rdata);
   assign hit       = rv_ff && m_hit;
   assign q_issue   = (state_ff == S_QSCAN) && (qn_ff < count_ff);
   assign h_issue   = (state_ff == S_HSCAN) && (hn_ff < hcount_ff);

   always_comb begin
      upd_entry       = q_entry;
      upd_entry.stat  = ST_ASSIGNED;
      upd_entry.robot = req_ff.robot_id;
   end

   // compare unit input: queue entry, or a history id in the id slot
   always_comb begin
      m_ctl.key = req_ff.order_id;
      m_entry   = q_entry;
      if (state_ff == S_HSCAN) begin
         m_ctl.mode = MATCH_ID;
         m_entry    = '0;
         m_entry.oid = h_rdata;
      end else begin
         case (req_ff.req_type)
            REQ_PEND:                m_ctl.mode = MATCH_PEND;
            REQ_ASSIGN, REQ_CONTAINS: m_ctl.mode = MATCH_ID;
            default:                 m_ctl.mode = MATCH_ANY;
         endcase
      end
   end

   ofs_match u_match (
      .ctl   (m_ctl),
      .entry (m_entry),
      .hit   (m_hit)
   );

   ofs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock (clock),
      .we    (qwe),
      .waddr (qwaddr),
      .wdata (qwdata),
      .raddr (qa_ff),
      .rdata (q_rdata)
   );

   ofs_ram #(.WIDTH(ID_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
      .clock (clock),
      .we    (hwe),
      .waddr (hcount_ff[HAW-1:0]),
      .wdata (req_data.order_id),
      .raddr (hn_ff[HAW-1:0]),
      .rdata (h_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      hcount_in    = hcount_ff;
      qa_in        = qa_ff;
      qn_in        = qn_ff;
      rp_in        = rp_ff;
      hn_in        = hn_ff;
      rv_in        = 1'b0;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      qwe          = 1'b0;
      qwaddr       = tail_ff;
      qwdata       = ENTRY_W'({req_data.order_id, req_data.item_id,
                               req_data.order_status, req_data.robot_id});
      hwe          = 1'b0;

      // output beat taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               qa_in    = head_ff;
               qn_in    = '0;
               hn_in    = '0;
               res_in   = '0;
               state_in = S_OUT;
               case (req_data.req_type)
                  REQ_ENQ: begin
                     if (count_ff != QFULL) begin
                        qwe       = 1'b1;
                        tail_in   = qnext(tail_ff);
                        count_in  = count_ff + 1'b1;
                        res_in.ok = 1'b1;
                     end
                  end
                  REQ_ADD: begin
                     if (hcount_ff != HFULL) begin
                        hwe       = 1'b1;
                        hcount_in = hcount_ff + 1'b1;
                        res_in.ok = 1'b1;
                     end
                  end
                  REQ_DEQ, REQ_PEEK, REQ_PEND, REQ_ASSIGN, REQ_CONTAINS: begin
                     state_in = S_QSCAN;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end

         S_QSCAN: begin
            if (q_issue) begin
               rv_in = 1'b1;
               qa_in = qnext(qa_ff);
               qn_in = qn_ff + 1'b1;
               rp_in = qa_ff;
            end
            if (hit) begin
               rv_in    = 1'b0;
               state_in = S_OUT;
               case (req_ff.req_type)
                  REQ_DEQ: begin
                     res_in   = rsp_of(q_entry);
                     head_in  = qnext(head_ff);
                     count_in = count_ff - 1'b1;
                  end
                  REQ_ASSIGN: begin
                     qwe    = 1'b1;
                     qwaddr = rp_ff;
                     qwdata = upd_entry;
                     res_in = rsp_of(upd_entry);
                  end
                  REQ_CONTAINS: begin
                     res_in.ok = 1'b1;
                  end
                  default: begin
                     res_in = rsp_of(q_entry);
                  end
               endcase
            end else if (!rv_ff && qn_ff == count_ff) begin
               // queue exhausted; contains goes on to the history
               state_in = (req_ff.req_type == REQ_CONTAINS) ? S_HSCAN : S_OUT;
            end
         end

         S_HSCAN: begin
            if (h_issue) begin
               rv_in = 1'b1;
               hn_in = hn_ff + 1'b1;
            end
            if (hit) begin
               rv_in     = 1'b0;
               res_in.ok = 1'b1;
               state_in  = S_OUT;
            end else if (!rv_ff && hn_ff == hcount_ff) begin
               state_in = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = res_ff;
               rsp_data_in.queue_count = CNT_W'(count_ff);
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         hcount_ff    <= '0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         hcount_ff    <= hcount_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan bookkeeping, no reset needed
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      qa_ff       <= qa_in;
      qn_ff       <= qn_in;
      rp_ff       <= rp_in;
      hn_ff       <= hn_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `OFS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept did not start work")
   `OFS_ASSERT_NEXT(a_enq_count, req_valid && !req_stall && req_data.req_type == REQ_ENQ && count_ff != QFULL, count_ff == $past(count_ff) + 1'b1, "enqueue did not bump count")
   `OFS_ASSERT_SAME(a_fail_fields_zero, rsp_valid && !rsp_data.ok, rsp_data.out_order_id == '0 && rsp_data.out_item_id == '0 && rsp_data.out_status == '0 && rsp_data.out_robot_id == '0, "failed beat carries entry data")
   `OFS_ASSERT_SAME(a_count_bounds, 1'b1, count_ff <= QFULL && hcount_ff <= HFULL, "count past capacity")

endmodule
